FILE: rtl/fad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fad_pkg: shared types and constants of the flow affinity dispatcher.
// Holds the payload structs, operation and status codes, and defaults.
// ----------------------------------------------------------------------------
package fad_pkg;

	localparam int NUM_WORKERS_DEF   = 8;
	localparam int QUEUE_DEPTH_DEF   = 16;
	localparam int TABLE_ENTRIES_DEF = 16;

	localparam logic [1:0] OP_DISPATCH = 2'd0;
	localparam logic [1:0] OP_START    = 2'd1;
	localparam logic [1:0] OP_FINISH   = 2'd2;
	localparam logic [1:0] OP_INVALID  = 2'd3;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_QUEUE_FULL = 2'd1;
	localparam logic [1:0] ST_TABLE_FULL = 2'd2;
	localparam logic [1:0] ST_BAD        = 2'd3;

	localparam logic [7:0] REFS_MAX = 8'd255;

	// Register addresses (byte address / 4).
	localparam logic REG_ORDER_ENABLE = 1'b0;
	localparam logic REG_WORKER_COUNT = 1'b1;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] dest_id;
		logic        dest_concurrent;
		logic [2:0]  worker_index;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [2:0] queue_index;
		logic       affinity_hit;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_TSCAN,
		S_TWAIT,
		S_DECIDE,
		S_CSCAN,
		S_CWAIT,
		S_APPLY,
		S_DONE
	} state_t;

endpackage

FILE: rtl/fad_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fad_ram: generic single-port synchronous RAM.
// One write or read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module fad_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write-first is not needed; plain read-old behavior.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

FILE: rtl/flow_affinity_dispatcher_top.sv
`timescale 1ns / 1ps
// Every item sweeps the affinity table memory (one entry a cycle, stopping
// early after a match) and then scans the queue fills (one queue a cycle); start and
// finish items run the same steps. One item in flight; the next input transfer can
// come in the cycle after the result transfer. Reset (arst_n low) clears fills,
// busy marks, pin valid bits, state.
// ----------------------------------------------------------------------------
// flow_affinity_dispatcher_top: spreads messages over worker queues.
// Pins each ordered destination to one queue in an affinity table memory.
// ----------------------------------------------------------------------------
module flow_affinity_dispatcher_top #(
	parameter int NUM_WORKERS   = fad_pkg::NUM_WORKERS_DEF,
	parameter int QUEUE_DEPTH   = fad_pkg::QUEUE_DEPTH_DEF,
	parameter int TABLE_ENTRIES = fad_pkg::TABLE_ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  fad_pkg::in_item_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output fad_pkg::out_item_t out_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int WB = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
	localparam int TB = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int FB = $clog2(QUEUE_DEPTH + 1);
	localparam int EW = 32 + 3 + 8;
	localparam int TCB = $clog2(TABLE_ENTRIES + 1);
	localparam int WCB = $clog2(NUM_WORKERS + 1);

	// Configuration registers.
	logic       order_enable_q;
	logic [3:0] worker_count_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_enable_q <= 1'b1;
			worker_count_q <= 4'd8;
		end else if (cfg_wr) begin
			if (paddr[2] == fad_pkg::REG_ORDER_ENABLE) begin
				order_enable_q <= pwdata[0];
			end else begin
				worker_count_q <= pwdata[3:0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == fad_pkg::REG_ORDER_ENABLE) begin
			prdata[0] = order_enable_q;
		end else begin
			prdata[3:0] = worker_count_q;
		end
	end

	// Active queue count, clamped to the built count.
	logic [WCB-1:0] n_act;
	always_comb begin
		if (worker_count_q == 4'd0 || 32'(worker_count_q) > NUM_WORKERS) begin
			n_act = WCB'(NUM_WORKERS);
		end else begin
			n_act = WCB'(worker_count_q);
		end
	end

	// Per-queue state, candidate and pin valid bits in flip-flops (small, read at fixed scan positions).
	logic [FB-1:0]  fill_q [NUM_WORKERS];
	logic [NUM_WORKERS-1:0] busy_q;
	logic [WB-1:0]  cand_q;
	logic [TABLE_ENTRIES-1:0] pvalid_q;

	// Affinity table memory: key, queue, refs.
	logic          ram_we;
	logic [TB-1:0] ram_addr;
	logic [EW-1:0] ram_wdata, ram_rdata;

	fad_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	fad_pkg::state_t state_q, state_d;
	fad_pkg::in_item_t item_q;
	logic [TCB-1:0] tidx_q;     // table sweep index
	logic [TB-1:0]  rd_idx_s1;  // entry whose read is in flight
	logic           rd_pend_s1;
	logic           found_q;
	logic [TB-1:0]  hit_e_q;
	logic [2:0]     pq_q;
	logic [7:0]     refs_q;
	logic           free_found_q;
	logic [TB-1:0]  free_e_q;
	// Candidate scan state.
	logic [WB-1:0]  cur_q, sidx_q, best_q;
	logic [FB:0]    best_fill_q;
	logic           scan_done_q;

	logic           order;
	assign order = order_enable_q && !item_q.dest_concurrent;

	logic in_fire, out_fire;
	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;
	assign in_ready = (state_q == fad_pkg::S_IDLE);

	// Memory port: sweep reads, or write in APPLY.
	logic          wr_en;
	logic [TB-1:0] wr_addr;
	logic [EW-1:0] wr_data;
	always_comb begin
		ram_we    = wr_en;
		ram_addr  = wr_en ? wr_addr : tidx_q[TB-1:0];
		ram_wdata = wr_data;
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			fad_pkg::S_IDLE:   if (in_fire) state_d = fad_pkg::S_TSCAN;
			fad_pkg::S_TSCAN:  if (tidx_q == TCB'(TABLE_ENTRIES - 1) || found_q)
				state_d = fad_pkg::S_TWAIT;
			fad_pkg::S_TWAIT:  state_d = fad_pkg::S_DECIDE;
			fad_pkg::S_DECIDE: state_d = fad_pkg::S_CSCAN;
			fad_pkg::S_CSCAN:  if (scan_done_q) state_d = fad_pkg::S_CWAIT;
			fad_pkg::S_CWAIT:  state_d = fad_pkg::S_APPLY;
			fad_pkg::S_APPLY:  state_d = fad_pkg::S_DONE;
			fad_pkg::S_DONE:   if (out_fire) state_d = fad_pkg::S_IDLE;
			default:           state_d = fad_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fad_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Decision results computed in DECIDE.
	logic          use_pin_q, need_new_q, take_q, reject_q;
	logic [WB-1:0] q_sel_q;

	// Candidate start position.
	logic [WB-1:0] cur_c, nxt_c;
	always_comb begin
		cur_c = (WCB'(cand_q) >= n_act) ? '0 : cand_q;
		nxt_c = (WCB'(cur_c) + WCB'(1) >= n_act) ? '0 : WB'(cur_c + WB'(1));
	end

	// Entry read back during the sweep.
	logic [31:0] rd_key;
	logic [2:0]  rd_pq;
	logic [7:0]  rd_refs;
	assign {rd_key, rd_pq, rd_refs} = ram_rdata;

	// Final application values.
	logic [7:0]  refs_new;
	logic        q_full;
	logic [1:0]  st_c;
	logic        hit_c;
	logic [2:0]  qo_c;

	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = hit_e_q;
		wr_data  = {item_q.dest_id, pq_q, refs_q};
		refs_new = refs_q;
		q_full   = (32'(fill_q[q_sel_q]) >= QUEUE_DEPTH);
		st_c     = fad_pkg::ST_OK;
		hit_c    = 1'b0;
		qo_c     = 3'(q_sel_q);
		if (state_q == fad_pkg::S_APPLY) begin
			case (item_q.operation)
				fad_pkg::OP_DISPATCH: begin
					if (reject_q) begin
						st_c = fad_pkg::ST_TABLE_FULL;
						qo_c = 3'd0;
					end else if (use_pin_q) begin
						hit_c = 1'b1;
						refs_new = (refs_q < fad_pkg::REFS_MAX) ? refs_q + 8'd1 : refs_q;
						if (q_full) begin
							st_c = fad_pkg::ST_QUEUE_FULL;
							refs_new = (refs_new != 8'd0) ? refs_new - 8'd1 : refs_new;
						end
						wr_en   = 1'b1;
						wr_data = {item_q.dest_id, pq_q, refs_new};
					end else begin
						if (q_full) st_c = fad_pkg::ST_QUEUE_FULL;
						if (need_new_q) begin
							wr_en   = !q_full;
							wr_addr = free_e_q;
							wr_data = {item_q.dest_id, 3'(q_sel_q), 8'd1};
						end else if (order && found_q && q_full) begin
							// Unused out-of-range pin loses one reference.
							refs_new = (refs_q != 8'd0) ? refs_q - 8'd1 : refs_q;
							wr_en   = 1'b1;
							wr_data = {item_q.dest_id, pq_q, refs_new};
						end
					end
				end
				fad_pkg::OP_START: begin
					if (WCB'(item_q.worker_index) >= n_act ||
					    fill_q[item_q.worker_index[WB-1:0]] == '0) begin
						st_c = fad_pkg::ST_BAD;
						qo_c = 3'd0;
					end else begin
						qo_c = item_q.worker_index;
					end
				end
				fad_pkg::OP_FINISH: begin
					if (WCB'(item_q.worker_index) >= n_act) begin
						st_c = fad_pkg::ST_BAD;
						qo_c = 3'd0;
					end else begin
						qo_c = item_q.worker_index;
						if (order && found_q) begin
							hit_c    = 1'b1;
							refs_new = (refs_q != 8'd0) ? refs_q - 8'd1 : refs_q;
							wr_en    = 1'b1;
							wr_data  = {item_q.dest_id, pq_q, refs_new};
						end
					end
				end
				default: begin
					st_c = fad_pkg::ST_BAD;
					qo_c = 3'd0;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WORKERS; i++) fill_q[i] <= '0;
			busy_q     <= '0;
			cand_q     <= '0;
			pvalid_q   <= '0;
			out_valid  <= 1'b0;
			rd_pend_s1 <= 1'b0;
			found_q    <= 1'b0;
			free_found_q <= 1'b0;
			tidx_q     <= '0;
			scan_done_q <= 1'b0;
		end else begin
			rd_pend_s1 <= 1'b0;
			case (state_q)
				fad_pkg::S_IDLE: begin
					if (in_fire) begin
						item_q       <= in_data;
						tidx_q       <= '0;
						found_q      <= 1'b0;
						free_found_q <= 1'b0;
					end
				end
				fad_pkg::S_TSCAN, fad_pkg::S_TWAIT: begin
					// Issue one read a cycle; match the previous read.
					if (state_q == fad_pkg::S_TSCAN && !found_q) begin
						rd_idx_s1  <= tidx_q[TB-1:0];
						rd_pend_s1 <= 1'b1;
						if (tidx_q != TCB'(TABLE_ENTRIES - 1)) tidx_q <= tidx_q + TCB'(1);
						if (!pvalid_q[tidx_q[TB-1:0]] && !free_found_q) begin
							free_found_q <= 1'b1;
							free_e_q     <= tidx_q[TB-1:0];
						end
					end
					if (rd_pend_s1 && !found_q && pvalid_q[rd_idx_s1] &&
					    rd_key == item_q.dest_id) begin
						found_q <= 1'b1;
						hit_e_q <= rd_idx_s1;
						pq_q    <= rd_pq;
						refs_q  <= rd_refs;
					end
				end
				fad_pkg::S_DECIDE: begin
					use_pin_q  <= (item_q.operation == fad_pkg::OP_DISPATCH) && order &&
						found_q && (WCB'(pq_q) < n_act);
					need_new_q <= order && !found_q;
					reject_q   <= (item_q.operation == fad_pkg::OP_DISPATCH) && order &&
						!found_q && !free_found_q;
					take_q     <= (item_q.operation == fad_pkg::OP_DISPATCH) &&
						!(order && found_q && (WCB'(pq_q) < n_act)) &&
						!(order && !found_q && !free_found_q);
					q_sel_q    <= (order && found_q && (WCB'(pq_q) < n_act)) ?
						WB'(pq_q) : cur_c;
					cur_q       <= cur_c;
					sidx_q      <= nxt_c;
					best_q      <= nxt_c;
					best_fill_q <= '1;
					scan_done_q <= (nxt_c == cur_c);
				end
				fad_pkg::S_CSCAN: begin
					// Walk one queue a cycle from the current candidate.
					if (!scan_done_q) begin
						if (fill_q[sidx_q] == '0 && !busy_q[sidx_q]) begin
							best_q      <= sidx_q;
							scan_done_q <= 1'b1;
						end else begin
							if ({1'b0, fill_q[sidx_q]} < best_fill_q) begin
								best_q      <= sidx_q;
								best_fill_q <= {1'b0, fill_q[sidx_q]};
							end
							if (WCB'(sidx_q) + WCB'(1) >= n_act) begin
								sidx_q <= '0;
								scan_done_q <= (cur_q == '0);
							end else begin
								sidx_q <= WB'(sidx_q + WB'(1));
								scan_done_q <= (WB'(sidx_q + WB'(1)) == cur_q);
							end
						end
					end
				end
				fad_pkg::S_APPLY: begin
					out_data.status       <= st_c;
					out_data.queue_index  <= qo_c;
					out_data.affinity_hit <= hit_c;
					out_valid             <= 1'b1;
					if (take_q) cand_q <= best_q;
					case (item_q.operation)
						fad_pkg::OP_DISPATCH: begin
							if (!reject_q && !q_full)
								fill_q[q_sel_q] <= fill_q[q_sel_q] + FB'(1);
							// A new pin is made valid; a released pin at zero is freed.
							if (!reject_q && need_new_q && !q_full)
								pvalid_q[free_e_q] <= 1'b1;
							else if (wr_en && !need_new_q && refs_new == 8'd0)
								pvalid_q[hit_e_q] <= 1'b0;
						end
						fad_pkg::OP_START: begin
							if (st_c == fad_pkg::ST_OK) begin
								fill_q[item_q.worker_index[WB-1:0]] <=
									fill_q[item_q.worker_index[WB-1:0]] - FB'(1);
								busy_q[item_q.worker_index[WB-1:0]] <= 1'b1;
							end
						end
						fad_pkg::OP_FINISH: begin
							if (st_c == fad_pkg::ST_OK) begin
								busy_q[item_q.worker_index[WB-1:0]] <= 1'b0;
								if (wr_en && refs_new == 8'd0) pvalid_q[hit_e_q] <= 1'b0;
							end
						end
						default: ;
					endcase
				end
				fad_pkg::S_DONE: begin
					if (out_fire) out_valid <= 1'b0;
				end
				default: ;
			endcase
		end
	end

endmodule

FILE: rtl/fad_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fad_checker: port-level checks of the flow affinity dispatcher.
// Watches the handshakes and the result codes over time.
// ----------------------------------------------------------------------------
module fad_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input fad_pkg::out_item_t out_data,
	input logic               pready
);

	// One item at a time: no input taken while a result is pending.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken with result pending");

	// A pending result holds until its transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped or changed");

	// Table-full results carry queue zero and no hit.
	a_tfull: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == fad_pkg::ST_TABLE_FULL |->
		out_data.queue_index == 3'd0 && !out_data.affinity_hit)
		else $error("table full result malformed");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind flow_affinity_dispatcher_top fad_checker u_fad_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data),
	.pready    (pready)
);
